// ===== hdl/ced_pkg.sv =====
// shared types and constants for the cascaded echo delay
package ced_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int CFG_STG_W = 4;
  localparam int CFG_LEN_W = 19;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  // register indexes, taken from paddr[2]
  localparam logic REG_ACTIVE_STAGES = 1'b0;
  localparam logic REG_DELAY_LENGTH  = 1'b1;

  localparam logic [CFG_STG_W-1:0] ACTIVE_STAGES_RST = 4'd8;
  localparam logic [CFG_LEN_W-1:0] DELAY_LENGTH_RST  = 19'd262144;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAD,
    ST_STEP,
    ST_FINISH
  } ced_state_t;

endpackage

// ===== hdl/ced_line_mem.sv =====
// single-port-write, single-port-read delay line memory with registered read
module ced_line_mem #(
  parameter int DEPTH = 2097152,
  parameter int AW    = 21
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  ced_pkg::sample_t   wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output ced_pkg::sample_t   rdata
);
  import ced_pkg::*;

  sample_t mem [DEPTH];
  sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ced_sat_add.sv =====
// shared saturating adder for the running echo sum
module ced_sat_add (
  input  ced_pkg::sample_t a,
  input  ced_pkg::sample_t b,
  output ced_pkg::sample_t y
);
  import ced_pkg::*;

  logic signed [SAMPLE_W:0] sum;

  assign sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};

  // overflow when the two top bits disagree
  always_comb begin
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      y = sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      y = sum[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hdl/cascaded_echo_delay.sv =====
// top level of the cascaded echo delay: sequencer, config registers, output register
//
//  channel   direction  handshake                 payload
//  in        in         in_valid / in_ready       in_sample_in   (signed Q1.23)
//  out       out        out_valid / out_ready     out_sample_out (signed Q1.23, saturated)
//  config    in/out     psel penable pwrite pready paddr pwdata prdata (APB style)
//
// a transaction passes the accept state, a read lead state, one memory read-modify-write
// per stage (n = active stages clamped to STAGES) and a finish state; with no active
// stage it goes from accept straight to finish
// the single memory write/read port and the shared saturating adder set that sequence
// after reset a clearing pass writes zero to all STAGES*LINE_DEPTH entries, one per cycle,
// and in_ready stays low until it is done; config writes are taken meanwhile
// the output register lets the block take the next transaction while a result waits;
// a result that is not taken holds the sequencer in its finish cycle
module cascaded_echo_delay #(
  parameter int STAGES     = 8,
  parameter int LINE_DEPTH = 262144
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ced_pkg::sample_t              in_sample_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output ced_pkg::sample_t              out_sample_out,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ced_pkg::APB_AW-1:0]    paddr,
  input  logic [ced_pkg::APB_DW-1:0]    pwdata,
  output logic [ced_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import ced_pkg::*;

  localparam int Depth = STAGES * LINE_DEPTH;
  localparam int AW    = $clog2(Depth);
  localparam int PosW  = $clog2(LINE_DEPTH);
  localparam int LenW  = $clog2(LINE_DEPTH + 1);
  localparam int StgW  = $clog2(STAGES + 1);

  // sequencer state
  ced_state_t             state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [PosW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;   // next read address
  logic [AW-1:0]          wa_r, wa_nxt;       // write-back address of the stage in flight
  logic [StgW-1:0]        stage_r, stage_nxt; // stages issued so far
  logic [StgW-1:0]        nstg_r, nstg_nxt;   // stages for this transaction
  sample_t                sum_r, sum_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sample_t                out_data_r, out_data_nxt;

  // config registers
  logic [CFG_STG_W-1:0]   active_r;
  logic [CFG_LEN_W-1:0]   dlen_r;

  // memory and adder hookup
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  sample_t                mem_wdata;
  logic                   mem_re;
  sample_t                mem_rdata;
  sample_t                sat_sum;

  // effective settings
  logic [StgW-1:0]        n_eff;
  logic [LenW-1:0]        len_eff;
  logic [LenW-1:0]        pos_inc;
  logic [PosW-1:0]        pos_next;
  logic                   cfg_wr;

  // ---------------------------------------------------------------------------
  // config port, always ready, written in the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_STAGES_RST;
      dlen_r   <= DELAY_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ACTIVE_STAGES: active_r <= pwdata[CFG_STG_W-1:0];
        REG_DELAY_LENGTH:  dlen_r   <= pwdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE_STAGES: prdata = APB_DW'(active_r);
      REG_DELAY_LENGTH:  prdata = APB_DW'(dlen_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // clamped stage count and length, position advance with wrap
  // ---------------------------------------------------------------------------
  assign n_eff = (int'(active_r) > STAGES) ? StgW'(STAGES) : StgW'(active_r);

  always_comb begin
    if (dlen_r == '0) begin
      len_eff = LenW'(1);            // zero length behaves as one
    end else if (int'(dlen_r) > LINE_DEPTH) begin
      len_eff = LenW'(LINE_DEPTH);   // longer than the line: use the whole line
    end else begin
      len_eff = LenW'(dlen_r);
    end
  end

  // advance first, then wrap if at or past the length (covers a shrunk length)
  assign pos_inc  = LenW'(pos_r) + LenW'(1);
  assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[PosW-1:0];

  // ---------------------------------------------------------------------------
  // shared units
  // ---------------------------------------------------------------------------
  ced_line_mem #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  ced_sat_add u_add (
    .a (sum_r),
    .b (mem_rdata),
    .y (sat_sum)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      stage_r     <= '0;
      nstg_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      stage_r     <= stage_nxt;
      nstg_r      <= nstg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    wa_r       <= wa_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    addr_nxt      = addr_r;
    wa_nxt        = wa_r;
    stage_nxt     = stage_r;
    nstg_nxt      = nstg_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = wa_r;
    mem_wdata     = sum_r;
    mem_re        = 1'b0;
    in_ready      = 1'b0;

    // result taken downstream frees the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // zero one entry per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(Depth - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sum_nxt   = in_sample_in;
          addr_nxt  = AW'(pos_r);
          pos_nxt   = pos_next;
          stage_nxt = '0;
          nstg_nxt  = n_eff;
          state_nxt = (n_eff == '0) ? ST_FINISH : ST_LEAD;
        end
      end
      ST_LEAD: begin
        // first read, data arrives next cycle
        mem_re    = 1'b1;
        wa_nxt    = addr_r;
        addr_nxt  = addr_r + AW'(LINE_DEPTH);
        stage_nxt = stage_r + StgW'(1);
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        // store the running sum where the old value was, fold the old value in
        mem_we  = 1'b1;
        sum_nxt = sat_sum;
        if (stage_r < nstg_r) begin
          // overlap the next stage's read with this write
          mem_re    = 1'b1;
          wa_nxt    = addr_r;
          addr_nxt  = addr_r + AW'(LINE_DEPTH);
          stage_nxt = stage_r + StgW'(1);
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // one transaction at a time: no accept right after an accept
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready
  ) else $error("input accepted while a transaction is in flight");

  // the stage counter never passes the number of lines
  a_stage_bound: assert property (
    @(posedge clk) disable iff (!rst_n)
    int'(stage_r) <= STAGES && stage_r <= nstg_r || state_r == ST_IDLE
  ) else $error("stage counter out of range");

  // memory writes stay inside the line storage
  a_waddr_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    mem_we |-> int'(mem_waddr) < Depth
  ) else $error("delay line write out of range");

  // a finish cycle with a free output register always presents a result
  a_finish_delivers: assert property (
    @(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH && (!out_valid_r || out_ready) |=> out_valid
  ) else $error("finished transaction not presented");

endmodule

// ===== bench/cascaded_echo_delay_test.sv =====
// testbench for the cascaded echo delay: directed table, then randomized phases
`timescale 1ns / 100ps

module cascaded_echo_delay_test;
  import ced_pkg::*;

  localparam int STAGES     = 8;
  localparam int LINE_DEPTH = 262144;
  // one transaction passes accept, lead, one step per stage and finish inside the block, plus the output register
  localparam int SETTLE     = 16;
  localparam int PHASES     = 12;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_STAGES, ROW_LENGTH} row_kind_t;
  typedef enum logic [1:0] {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  typedef struct {
    row_kind_t kind;
    int        value;
    bit        sure;   // expected result typed in below, not predicted
    int        want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  sample_t               in_sample_in;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sample_t               out_sample_out;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  // predictor state: delay lines (only touched entries), shared tap position, registers
  sample_t               line_mem [int];
  int                    tap_pos;
  logic [CFG_STG_W-1:0]  cfg_stages;
  logic [CFG_LEN_W-1:0]  cfg_length;

  sample_t               echo_due [$];   // echoed samples still owed by the block
  sample_t               oldest;
  int                    err_count;
  int                    send_idle;      // percent of cycles the sender holds back
  int                    recv_stall;     // percent of cycles the receiver stalls
  plan_row_t             plan [$];

  // random phases: stage count, delay length, pacing, transaction count
  int    ph_stages [0:PHASES-1] = '{8, 3, 0, 1, 8, 15, 2, 9, 5, 8, 4, 7};
  int    ph_length [0:PHASES-1] = '{7, 1, 16, 40, 5, 0, 3, 524287, 2, 262144, 11, 9};
  pace_t ph_pace   [0:PHASES-1] = '{PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH,
                                    PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH,
                                    PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH};
  int    ph_count  [0:PHASES-1] = '{150, 100, 100, 150, 150, 120, 150, 150, 150, 100, 150, 80};

  cascaded_echo_delay #(
    .STAGES     (STAGES),
    .LINE_DEPTH (LINE_DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // one sample through the active stages: each stage stores the running sum at the
  // shared position and adds what it held there, saturating to 24 bits
  function automatic sample_t echo_chain(input sample_t x);
    int n;
    int len;
    int run;
    int held;
    int key;
    int s;
    n   = (cfg_stages > STAGES) ? STAGES : cfg_stages;
    len = (cfg_length == 0) ? 1 : ((cfg_length > LINE_DEPTH) ? LINE_DEPTH : cfg_length);
    run = int'(x);
    for (s = 0; s < n; s++) begin
      key  = s * LINE_DEPTH + tap_pos;
      held = line_mem.exists(key) ? line_mem[key] : 0;
      line_mem[key] = sample_t'(run);
      run = run + held;
      if (run > SAMPLE_MAX) run = SAMPLE_MAX;
      if (run < SAMPLE_MIN) run = SAMPLE_MIN;
    end
    // advance first, then wrap: also covers a length shrunk below the position
    tap_pos = (tap_pos + 1 >= len) ? 0 : tap_pos + 1;
    return sample_t'(run);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return sample_t'(int'($urandom_range(8191)) - 4096);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic plan_row_t row(input row_kind_t k, input int v,
                                    input bit sure = 1'b0, input int want = 0);
    plan_row_t r;
    r.kind  = k;
    r.value = v;
    r.sure  = sure;
    r.want  = want;
    return r;
  endfunction

  // valid stays up across back-to-back transactions; it only drops for an idle gap
  task automatic send_sample(input sample_t x, input bit sure, input sample_t want);
    sample_t guess;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = echo_chain(x);
    echo_due.push_back(sure ? want : guess);
  endtask

  // wait until every owed result is out and the sequencer has gone idle
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (echo_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup phase, access phase, then a quiet idle phase so back-to-back calls never overlap
  task automatic cfg_access(input logic idx, input logic wr, input logic [31:0] word,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write with junk above the register width, then read back the kept bits
  task automatic set_reg(input logic idx, input int value);
    logic [31:0] word;
    logic [31:0] rd;
    logic [31:0] kept;
    word = $urandom();
    if (idx == REG_ACTIVE_STAGES) begin
      word[CFG_STG_W-1:0] = CFG_STG_W'(value);
      cfg_stages = word[CFG_STG_W-1:0];
      kept = 32'(cfg_stages);
    end else begin
      word[CFG_LEN_W-1:0] = CFG_LEN_W'(value);
      cfg_length = word[CFG_LEN_W-1:0];
      kept = 32'(cfg_length);
    end
    cfg_access(idx, 1'b1, word, rd);
    cfg_access(idx, 1'b0, '0, rd);
    if (rd !== kept) begin
      note_failure($sformatf("register %0d read back: expected %0d, got %0d", idx, kept, rd));
    end
  endtask

  // result side: random stalls, every transaction checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (echo_due.size() == 0) begin
        note_failure($sformatf("result %0d with nothing expected", out_sample_out));
      end else begin
        oldest = echo_due.pop_front();
        if (out_sample_out !== oldest) begin
          note_failure($sformatf("sample_out: expected %0d, got %0d", oldest, out_sample_out));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // the timeout covers the clearing pass over all STAGES*LINE_DEPTH entries with ample margin
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    err_count    = 0;
    send_idle    = 0;
    recv_stall   = 0;
    tap_pos      = 0;
    cfg_stages   = ACTIVE_STAGES_RST;
    cfg_length   = DELAY_LENGTH_RST;

    // fresh lines at fresh positions echo nothing, so these come straight back
    plan.push_back(row(ROW_SAMPLE, 0, 1'b1, 0));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MAX), 1'b1, int'(SAMPLE_MAX)));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MIN), 1'b1, int'(SAMPLE_MIN)));
    plan.push_back(row(ROW_SAMPLE, 1, 1'b1, 1));
    plan.push_back(row(ROW_SAMPLE, -1, 1'b1, -1));
    plan.push_back(row(ROW_SAMPLE, 'h2AAAAA, 1'b1, 'h2AAAAA));
    plan.push_back(row(ROW_SAMPLE, -'h2AAAAB, 1'b1, -'h2AAAAB));
    // zero length acts as one, and the position is already past it
    plan.push_back(row(ROW_LENGTH, 0));
    plan.push_back(row(ROW_SAMPLE, 'h123456, 1'b1, 'h123456));
    plan.push_back(row(ROW_SAMPLE, 'h100000));
    plan.push_back(row(ROW_SAMPLE, 'h100000));
    // no stages: plain pass-through
    plan.push_back(row(ROW_STAGES, 0));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MAX), 1'b1, int'(SAMPLE_MAX)));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MIN), 1'b1, int'(SAMPLE_MIN)));
    // stage count beyond the line count, pushed into saturation both ways
    plan.push_back(row(ROW_STAGES, 15));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MAX)));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MAX)));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MIN)));
    plan.push_back(row(ROW_SAMPLE, int'(SAMPLE_MIN)));
    // length beyond the line depth
    plan.push_back(row(ROW_LENGTH, 524287));
    plan.push_back(row(ROW_STAGES, 1));
    plan.push_back(row(ROW_SAMPLE, -5));
    plan.push_back(row(ROW_SAMPLE, 77));
    plan.push_back(row(ROW_LENGTH, 3));
    plan.push_back(row(ROW_SAMPLE, 12345));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, walked in order
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_SAMPLE: send_sample(sample_t'(plan[i].value), plan[i].sure,
                                sample_t'(plan[i].want));
        ROW_STAGES: begin
          settle_idle();
          set_reg(REG_ACTIVE_STAGES, plan[i].value);
        end
        default: begin
          settle_idle();
          set_reg(REG_DELAY_LENGTH, plan[i].value);
        end
      endcase
    end

    // random phases, each with its own settings and pacing
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      set_reg(REG_ACTIVE_STAGES, ph_stages[p]);
      set_reg(REG_DELAY_LENGTH, ph_length[p]);
      case (ph_pace[p])
        PACE_NONE: begin send_idle = 0;  recv_stall = 0;  end
        PACE_SEND: begin send_idle = 61; recv_stall = 0;  end
        PACE_RECV: begin send_idle = 0;  recv_stall = 61; end
        default:   begin send_idle = 24; recv_stall = 24; end
      endcase
      for (int n = 0; n < ph_count[p]; n++) begin
        send_sample(pick_sample(), 1'b0, '0);
      end
    end

    settle_idle();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ced_pkg.sv
hdl/ced_line_mem.sv
hdl/ced_sat_add.sv
hdl/cascaded_echo_delay.sv
bench/cascaded_echo_delay_test.sv
